// File: rtl/sor_pkg.sv
// shared constants, types and sweep-order functions of the sor poisson solver
`default_nettype none
package sor_pkg;

	localparam int GRID_N = 64;
	localparam int TILE_SIZE = 4;
	localparam int SIDE = GRID_N + 1;
	localparam int CELLS = SIDE * SIDE;
	localparam int TILES = (GRID_N - 1) / TILE_SIZE;
	localparam int EDGE = TILES * TILE_SIZE + 1;

	localparam int IDX_W = $clog2(SIDE + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int TW = $clog2(TILES + 2);
	localparam int OW = $clog2(TILE_SIZE + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_SOLVE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [2:0] REG_RELAX = 3'd0;
	localparam logic [2:0] REG_WX = 3'd1;
	localparam logic [2:0] REG_WY = 3'd2;
	localparam logic [2:0] REG_SRC = 3'd3;
	localparam logic [2:0] REG_TOL = 3'd4;
	localparam logic [2:0] REG_MAXS = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE, S_RDOUT, S_LOAD, S_MA, S_MB, S_MC, S_WB, S_CHECK
	} state_t;

	typedef enum logic [1:0] {PH_UP, PH_LO, PH_RC, PH_RR} phase_t;

	typedef struct packed {
		logic over;
		phase_t phase;
		logic [TW-1:0] d;
		logic [TW-1:0] t;
		logic [OW-1:0] oi;
		logic [OW-1:0] oj;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} walk_t;

	function automatic logic present(input logic [1:0] p);
		logic r;
		begin
			case (p)
				2'd0: r = (TILES > 0);
				2'd1: r = (TILES > 1);
				2'd2: r = (TILES > 0) && (EDGE < GRID_N);
				default: r = (EDGE < GRID_N);
			endcase
			return r;
		end
	endfunction

	function automatic walk_t enter_from(input logic [1:0] from);
		walk_t w;
		logic found;
		begin
			w = '0;
			w.over = 1'b1;
			found = 1'b0;
			for (int k = 0; k < 4; k++) begin
				if (!found && 2'(k) >= from && present(2'(k))) begin
					found = 1'b1;
					w.over = 1'b0;
					w.phase = phase_t'(2'(k));
					w.d = (k == 1) ? TW'(1) : '0;
					w.i = (k == 3) ? IDX_W'(EDGE) : IDX_W'(1);
					w.j = (k == 2) ? IDX_W'(EDGE) : IDX_W'(1);
				end
			end
			return w;
		end
	endfunction

	function automatic walk_t advance(input walk_t w);
		walk_t n;
		begin
			n = w;
			case (w.phase)
				PH_UP, PH_LO: begin
					if (w.oj != OW'(TILE_SIZE - 1)) begin
						n.oj = w.oj + 1'b1;
					end else if (w.oi != OW'(TILE_SIZE - 1)) begin
						n.oj = '0;
						n.oi = w.oi + 1'b1;
					end else begin
						n.oi = '0;
						n.oj = '0;
						if (w.phase == PH_UP) begin
							if (w.t != w.d) begin
								n.t = w.t + 1'b1;
							end else if (w.d != TW'(TILES - 1)) begin
								n.d = w.d + 1'b1;
								n.t = '0;
							end else begin
								n = enter_from(2'd1);
							end
						end else begin
							if (w.t != TW'(TILES - 1) - w.d) begin
								n.t = w.t + 1'b1;
							end else if (w.d != TW'(TILES - 1)) begin
								n.d = w.d + 1'b1;
								n.t = '0;
							end else begin
								n = enter_from(2'd2);
							end
						end
					end
				end
				PH_RC: begin
					if (w.j != IDX_W'(GRID_N - 1)) begin
						n.j = w.j + 1'b1;
					end else if (w.i != IDX_W'(EDGE - 1)) begin
						n.i = w.i + 1'b1;
						n.j = IDX_W'(EDGE);
					end else begin
						n = enter_from(2'd3);
					end
				end
				default: begin
					if (w.j != IDX_W'(GRID_N - 1)) begin
						n.j = w.j + 1'b1;
					end else if (w.i != IDX_W'(GRID_N - 1)) begin
						n.i = w.i + 1'b1;
						n.j = IDX_W'(1);
					end else begin
						n.over = 1'b1;
					end
				end
			endcase
			return n;
		end
	endfunction

	function automatic logic [IDX_W-1:0] walk_row(input walk_t w);
		logic [IDX_W-1:0] rb;
		logic [IDX_W-1:0] r;
		begin
			if (w.phase == PH_UP) rb = IDX_W'(w.d) - IDX_W'(w.t);
			else rb = IDX_W'(TILES - 1) - IDX_W'(w.t);
			if (w.phase == PH_UP || w.phase == PH_LO)
				r = IDX_W'(rb * IDX_W'(TILE_SIZE)) + IDX_W'(1) + IDX_W'(w.oi);
			else
				r = w.i;
			return r;
		end
	endfunction

	function automatic logic [IDX_W-1:0] walk_col(input walk_t w);
		logic [IDX_W-1:0] cb;
		logic [IDX_W-1:0] c;
		begin
			if (w.phase == PH_UP) cb = IDX_W'(w.t);
			else cb = IDX_W'(w.d) + IDX_W'(w.t);
			if (w.phase == PH_UP || w.phase == PH_LO)
				c = IDX_W'(cb * IDX_W'(TILE_SIZE)) + IDX_W'(1) + IDX_W'(w.oj);
			else
				c = w.j;
			return c;
		end
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(SIDE)) + ADDR_W'(c);
	endfunction

endpackage
`default_nettype wire

// File: rtl/sor_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module sor_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/blocked_sor_poisson_solver.sv
// top level of the blocked sor poisson solver
// usage: an item is taken when start is high and busy is low. action write
// stores point_value at (point_row, point_col), action read returns the grid
// value, action solve runs sor sweeps over the interior in tiled wavefront
// order. every item gives one result word, marked by done for one cycle,
// with read_value, sweeps_done and converged.
// solve steps per interior point: five reads on the single grid ram read
// port, three multiply steps, one write back; each sweep ends with a
// convergence check, up to max_sweeps sweeps.
// one item at a time: busy stays high until the result is shown, and a
// write can be taken in the cycle its predecessor's done is high.
// config: cfg_valid/cfg_ready write channel, always ready, use when idle.
// reset clears control, sweep count and converged flag; grid contents are
// undefined until written. the receiver cannot stall results.
`default_nettype none
module blocked_sor_poisson_solver (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] action,
	input wire logic [sor_pkg::IDX_W-1:0] point_row,
	input wire logic [sor_pkg::IDX_W-1:0] point_col,
	input wire logic signed [31:0] point_value,
	output logic done,
	output logic signed [31:0] read_value,
	output logic [15:0] sweeps_done,
	output logic converged,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	import sor_pkg::*;

	state_t state_q, state_d;
	walk_t walk_q, walk_d, walk_nx;
	logic [2:0] load_cnt_q, load_cnt_d;
	logic [31:0] largest_q, largest_d;
	logic [15:0] sweeps_q, sweeps_d;
	logic conv_q, conv_d;
	logic fin;
	logic rd_ok_q;

	logic [16:0] relax_q;
	logic [15:0] wx_q, wy_q, tol_q, maxs_q;
	logic signed [31:0] src_q;

	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [DATA_W-1:0] mem_wd, mem_rd;

	logic signed [31:0] old_q, left_q, right_q, up_q, down_q;
	logic signed [49:0] px_q, py_q, po_q;
	logic signed [35:0] inner_q;
	logic signed [53:0] pw_q;
	logic signed [38:0] nv;
	logic signed [31:0] nv_sat;
	logic signed [32:0] diff;
	logic [31:0] adiff;
	logic signed [17:0] om;

	logic [IDX_W-1:0] pr, pc;
	logic in_ok;

	sor_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
		.re(mem_re), .raddr(mem_ra), .rdata(mem_rd)
	);

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign sweeps_done = sweeps_q;
	assign converged = conv_q;
	assign pr = walk_row(walk_q);
	assign pc = walk_col(walk_q);
	assign walk_nx = advance(walk_q);
	assign in_ok = (point_row <= IDX_W'(GRID_N)) && (point_col <= IDX_W'(GRID_N));

	assign om = 18'sd65536 - $signed({1'b0, relax_q});
	assign nv = 39'(pw_q >>> 16) + 39'(po_q >>> 16);
	always_comb begin
		if (nv > 39'sd2147483647) nv_sat = 32'sh7fffffff;
		else if (nv < -39'sd2147483648) nv_sat = 32'sh80000000;
		else nv_sat = 32'(nv);
		diff = 33'(nv_sat) - 33'(old_q);
		adiff = diff[32] ? 32'(-diff) : 32'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		walk_d = walk_q;
		load_cnt_d = load_cnt_q;
		largest_d = largest_q;
		sweeps_d = sweeps_q;
		conv_d = conv_q;
		fin = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = cell_addr(pr, pc);
		mem_wd = nv_sat;
		mem_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_WRITE: begin
							mem_we = in_ok;
							mem_wa = cell_addr(point_row, point_col);
							mem_wd = point_value;
							fin = 1'b1;
						end
						ACT_SOLVE: begin
							sweeps_d = '0;
							conv_d = 1'b0;
							largest_d = '0;
							walk_d = enter_from(2'd0);
							load_cnt_d = '0;
							if (maxs_q == '0) fin = 1'b1;
							else state_d = S_LOAD;
						end
						ACT_READ: begin
							mem_re = in_ok;
							mem_ra = in_ok ? cell_addr(point_row, point_col) : '0;
							state_d = S_RDOUT;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_RDOUT: begin
				fin = 1'b1;
				state_d = S_IDLE;
			end
			S_LOAD: begin
				mem_re = (load_cnt_q < 3'd5);
				case (load_cnt_q)
					3'd0: mem_ra = cell_addr(pr, pc);
					3'd1: mem_ra = cell_addr(pr - 1'b1, pc);
					3'd2: mem_ra = cell_addr(pr + 1'b1, pc);
					3'd3: mem_ra = cell_addr(pr, pc + 1'b1);
					default: mem_ra = cell_addr(pr, pc - 1'b1);
				endcase
				if (load_cnt_q == 3'd5) state_d = S_MA;
				else load_cnt_d = load_cnt_q + 1'b1;
			end
			S_MA: state_d = S_MB;
			S_MB: state_d = S_MC;
			S_MC: state_d = S_WB;
			S_WB: begin
				mem_we = 1'b1;
				if (adiff > largest_q) largest_d = adiff;
				load_cnt_d = '0;
				walk_d = walk_nx;
				state_d = walk_nx.over ? S_CHECK : S_LOAD;
			end
			S_CHECK: begin
				sweeps_d = sweeps_q + 1'b1;
				if (largest_q < {16'd0, tol_q}) begin
					conv_d = 1'b1;
					fin = 1'b1;
					state_d = S_IDLE;
				end else if (sweeps_q + 1'b1 >= maxs_q) begin
					fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					largest_d = '0;
					walk_d = enter_from(2'd0);
					load_cnt_d = '0;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			load_cnt_q <= '0;
			largest_q <= '0;
			sweeps_q <= '0;
			conv_q <= 1'b0;
			done <= 1'b0;
			rd_ok_q <= 1'b0;
			relax_q <= 17'd124941;
			wx_q <= 16'd16384;
			wy_q <= 16'd16384;
			src_q <= -32'sd64;
			tol_q <= 16'd1;
			maxs_q <= 16'd246;
		end else begin
			walk_q <= walk_d;
			load_cnt_q <= load_cnt_d;
			largest_q <= largest_d;
			sweeps_q <= sweeps_d;
			conv_q <= conv_d;
			done <= fin;
			if (state_q == S_IDLE && start) rd_ok_q <= in_ok;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RELAX: relax_q <= cfg_data[16:0];
					REG_WX: wx_q <= cfg_data[15:0];
					REG_WY: wy_q <= cfg_data[15:0];
					REG_SRC: src_q <= cfg_data;
					REG_TOL: tol_q <= cfg_data[15:0];
					REG_MAXS: maxs_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) read_value <= (state_q == S_RDOUT && rd_ok_q) ? mem_rd : '0;
		if (state_q == S_LOAD) begin
			case (load_cnt_q)
				3'd1: old_q <= mem_rd;
				3'd2: left_q <= mem_rd;
				3'd3: right_q <= mem_rd;
				3'd4: up_q <= mem_rd;
				3'd5: down_q <= mem_rd;
				default: ;
			endcase
		end
		if (state_q == S_MA) begin
			px_q <= $signed({1'b0, wx_q}) * (33'(left_q) + 33'(right_q));
			py_q <= $signed({1'b0, wy_q}) * (33'(up_q) + 33'(down_q));
			po_q <= om * old_q;
		end
		if (state_q == S_MB)
			inner_q <= 36'(px_q >>> 16) + 36'(py_q >>> 16) + 36'(src_q);
		if (state_q == S_MC)
			pw_q <= $signed({1'b0, relax_q}) * inner_q;
	end

	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= 3'd5) else $error("load counter overran");
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE || state_q == S_WB))
		else $error("grid write outside idle or write back");
	a_check_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(state_q) == S_WB)
		else $error("sweep check not after a write back");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == S_IDLE) else $error("result word while still working");

endmodule
`default_nettype wire
